// ===== hw/rtl/per_channel_clamped_histogram_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-channel clamped histogram
// Shared shorthand for the concurrent checks in the checker module.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_CLAMPED_HISTOGRAM_MACROS_SVH
`define PER_CHANNEL_CLAMPED_HISTOGRAM_MACROS_SVH

// Full form: explicit clock and active-low reset.
`define PCH_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form on the usual clock and reset names.
`define PCH_ASSERT(lbl, prop, msg) \
  `PCH_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/pch_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram package
// Sizes, bin mapping constants, command codes and shared types.
// ----------------------------------------------------------------------------
package pch_pkg;

  // Store geometry.
  localparam int NumChannels = 64;
  localparam int NumBins     = 128;
  localparam int StoreDepth  = NumChannels * NumBins;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int BinW        = $clog2(NumBins);

  // Field widths on the channels.
  localparam int CmdW   = 2;
  localparam int ChanW  = 6;
  localparam int ValueW = 24;
  localparam int SelW   = 7;
  localparam int IndexW = 7;
  localparam int CountW = 32;

  // Bin mapping: bin = (value - RangeStart) / BinWidth, clamped.
  localparam int HistRange  = 6000;
  localparam int BinWidth   = HistRange / NumBins;
  localparam int RangeStart = 0 - (HistRange / 2) + (BinWidth / 2);
  localparam int OffLimit   = NumBins * BinWidth;
  localparam int OffW       = $clog2(OffLimit);

  // Reciprocal multiply that is exact for offsets below OffLimit.
  localparam int DivShift = 26;
  localparam int DivMult  = ((2 ** DivShift) + BinWidth - 1) / BinWidth;
  localparam int ProdW    = DivShift + BinW + 1;

  // Queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CmdAdd   = 2'd0,
    CmdRead  = 2'd1,
    CmdClear = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  // One classified command, as queued for the back.
  typedef struct packed {
    cmd_e              op;
    logic              hit;
    logic [AddrW-1:0]  addr;
    logic [IndexW-1:0] index;
  } job_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackData,
    BackClear
  } back_state_e;

endpackage

// ===== hw/rtl/pch_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one histogram command per transaction.
// ----------------------------------------------------------------------------
interface pch_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [pch_pkg::CmdW-1:0]      cmd;
  logic [pch_pkg::ChanW-1:0]     channel;
  logic signed [pch_pkg::ValueW-1:0] sample_value;
  logic [pch_pkg::SelW-1:0]      bin_select;

  modport source (output valid, cmd, channel, sample_value, bin_select, input ready);
  modport sink   (input valid, cmd, channel, sample_value, bin_select, output ready);
endinterface

// ===== hw/rtl/pch_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one histogram result per transaction.
// ----------------------------------------------------------------------------
interface pch_res_if;
  logic                        valid;
  logic                        ready;
  logic [pch_pkg::IndexW-1:0]  bin_index;
  logic [pch_pkg::CountW-1:0]  bin_count;

  modport source (output valid, bin_index, bin_count, input ready);
  modport sink   (input valid, bin_index, bin_count, output ready);
endinterface

// ===== hw/rtl/pch_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pch_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pch_front.sv =====
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts commands, maps sample values to bins and forms store addresses.
// ----------------------------------------------------------------------------
module pch_front (
  pch_cmd_if.sink         in_chan_i,
  input  logic            init_busy_i,
  output pch_pkg::job_t   job_o,
  output logic            job_valid_o,
  input  logic            job_ready_i
);

  logic signed [pch_pkg::ValueW:0]  off;
  logic [pch_pkg::ProdW-1:0]        prod;
  logic [pch_pkg::BinW-1:0]         bin;
  logic [pch_pkg::BinW-1:0]         sel_bin;
  logic [pch_pkg::AddrW-1:0]        base;
  logic                             chan_ok;
  logic                             sel_ok;

  // No commands are taken while the store is being cleared after reset.
  assign job_valid_o     = in_chan_i.valid && !init_busy_i;
  assign in_chan_i.ready = job_ready_i && !init_busy_i;

  always_comb begin
    off  = (pch_pkg::ValueW + 1)'(in_chan_i.sample_value)
         - (pch_pkg::ValueW + 1)'(pch_pkg::RangeStart);
    prod = pch_pkg::ProdW'(off[pch_pkg::OffW-1:0]) * pch_pkg::ProdW'(pch_pkg::DivMult);
    if (off[pch_pkg::ValueW]) begin
      bin = '0;
    end else if (off >= (pch_pkg::ValueW + 1)'(pch_pkg::OffLimit)) begin
      bin = pch_pkg::BinW'(pch_pkg::NumBins - 1);
    end else begin
      bin = prod[pch_pkg::DivShift +: pch_pkg::BinW];
    end
  end

  always_comb begin
    chan_ok = 32'(in_chan_i.channel) < 32'(pch_pkg::NumChannels);
    sel_ok  = 32'(in_chan_i.bin_select) < 32'(pch_pkg::NumBins);
    sel_bin = pch_pkg::BinW'(in_chan_i.bin_select);
    base    = pch_pkg::AddrW'(pch_pkg::AddrW'(in_chan_i.channel)
                              * pch_pkg::AddrW'(pch_pkg::NumBins));

    job_o.op    = pch_pkg::cmd_e'(in_chan_i.cmd);
    job_o.hit   = 1'b0;
    job_o.addr  = '0;
    job_o.index = '0;
    unique case (pch_pkg::cmd_e'(in_chan_i.cmd))
      pch_pkg::CmdAdd: begin
        job_o.hit   = chan_ok;
        job_o.addr  = base + pch_pkg::AddrW'(bin);
        job_o.index = pch_pkg::IndexW'(bin);
      end
      pch_pkg::CmdRead: begin
        job_o.hit   = chan_ok && sel_ok;
        job_o.addr  = base + pch_pkg::AddrW'(sel_bin);
        job_o.index = pch_pkg::IndexW'(in_chan_i.bin_select);
      end
      default: begin
        job_o.hit = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pch_queue.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module pch_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pch_pkg::job_t   push_job_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output pch_pkg::job_t   pop_job_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  pch_pkg::job_t              entry_q [pch_pkg::QueueDepth];
  logic [pch_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [pch_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [pch_pkg::QCntW-1:0]  count_q, count_d;
  logic                       push, pop;

  assign push_ready_o = count_q != pch_pkg::QCntW'(pch_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pch_pkg::QPtrW'(pch_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + pch_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pch_pkg::QPtrW'(pch_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + pch_pkg::QPtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + pch_pkg::QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - pch_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== hw/rtl/pch_back.sv =====
// ----------------------------------------------------------------------------
// Histogram back end
// Owns the counter store: read-modify-write, reads, clear walk and result.
// ----------------------------------------------------------------------------
module pch_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pch_pkg::job_t   job_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  pch_res_if.source       out_chan_o,
  output logic            init_busy_o
);

  pch_pkg::back_state_e         state_q, state_d;
  pch_pkg::job_t                job_q, job_d;
  logic [pch_pkg::AddrW-1:0]    clr_ptr_q, clr_ptr_d;
  logic                         clr_report_q, clr_report_d;
  logic                         out_valid_q, out_valid_d;
  logic [pch_pkg::IndexW-1:0]   out_index_q, out_index_d;
  logic [pch_pkg::CountW-1:0]   out_count_q, out_count_d;

  logic                         out_free;
  logic                         clr_last;
  logic                         ram_we;
  logic [pch_pkg::AddrW-1:0]    ram_waddr;
  logic [pch_pkg::CountW-1:0]   ram_wdata;
  logic [pch_pkg::CountW-1:0]   ram_rdata;
  logic [pch_pkg::CountW-1:0]   inc_count;

  assign out_free = !out_valid_q || out_chan_o.ready;
  assign clr_last = clr_ptr_q == pch_pkg::AddrW'(pch_pkg::StoreDepth - 1);

  // Saturating increment of the counter that was just read.
  assign inc_count = (ram_rdata == '1) ? ram_rdata : ram_rdata + pch_pkg::CountW'(1);

  pch_ram #(
    .Width (pch_pkg::CountW),
    .Depth (pch_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (job_i.addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pch_pkg::BackIdle: begin
        if (job_valid_i && out_free) begin
          state_d = (job_i.op == pch_pkg::CmdClear) ? pch_pkg::BackClear
                                                    : pch_pkg::BackData;
        end
      end
      pch_pkg::BackData: begin
        state_d = pch_pkg::BackIdle;
      end
      pch_pkg::BackClear: begin
        if (clr_last && (!clr_report_q || out_free)) begin
          state_d = pch_pkg::BackIdle;
        end
      end
      default: begin
        state_d = pch_pkg::BackIdle;
      end
    endcase
  end

  always_comb begin
    job_ready_o  = 1'b0;
    job_d        = job_q;
    clr_ptr_d    = clr_ptr_q;
    clr_report_d = clr_report_q;
    ram_we       = 1'b0;
    ram_waddr    = job_q.addr;
    ram_wdata    = inc_count;
    out_valid_d  = out_chan_o.ready ? 1'b0 : out_valid_q;
    out_index_d  = out_index_q;
    out_count_d  = out_count_q;
    unique case (state_q)
      pch_pkg::BackIdle: begin
        job_ready_o = out_free;
        if (job_valid_i && out_free) begin
          job_d        = job_i;
          clr_ptr_d    = '0;
          clr_report_d = 1'b1;
        end
      end
      pch_pkg::BackData: begin
        ram_we      = (job_q.op == pch_pkg::CmdAdd) && job_q.hit;
        out_valid_d = 1'b1;
        out_index_d = job_q.index;
        if (!job_q.hit) begin
          out_count_d = '0;
        end else if (job_q.op == pch_pkg::CmdAdd) begin
          out_count_d = inc_count;
        end else if (job_q.op == pch_pkg::CmdRead) begin
          out_count_d = ram_rdata;
        end else begin
          out_count_d = '0;
        end
      end
      pch_pkg::BackClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_q;
        ram_wdata = '0;
        if (!clr_last) begin
          clr_ptr_d = clr_ptr_q + pch_pkg::AddrW'(1);
        end else if (clr_report_q && out_free) begin
          out_valid_d = 1'b1;
          out_index_d = '0;
          out_count_d = '0;
        end
      end
      default: begin
        job_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pch_pkg::BackClear;
      clr_ptr_q    <= '0;
      clr_report_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_ptr_q    <= clr_ptr_d;
      clr_report_q <= clr_report_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    out_index_q <= out_index_d;
    out_count_q <= out_count_d;
  end

  assign init_busy_o          = (state_q == pch_pkg::BackClear) && !clr_report_q;
  assign out_chan_o.valid     = out_valid_q;
  assign out_chan_o.bin_index = out_index_q;
  assign out_chan_o.bin_count = out_count_q;

endmodule

// ===== hw/rtl/per_channel_clamped_histogram.sv =====
// ----------------------------------------------------------------------------
// Per-channel clamped histogram
// 64 channels of 128 saturating 32-bit bin counters with add, read and clear.
// ----------------------------------------------------------------------------
// Every command transaction gives exactly one result transaction, in order.
// An add maps the sample (thousandths) to bin (value + 2977) / 46, clamped to
// 0..127, bumps that counter (saturating) and returns the bin and new count.
// A read returns the stored count of the selected bin, and a clear zeroes the
// whole store and then returns index 0 with count 0. Add, read and the unused
// command code go from the BackIdle state, which reads the counter from the
// single store RAM, to BackData, which writes back an add and registers the
// result, so the back end takes a new command only once it is done with the
// last. A clear walks the whole store in the back end, one store word written
// per cycle. Right after reset the same walk runs with the command channel
// held not ready. A two-entry queue lets the front keep accepting commands
// while the back is busy or a result waits to be taken.
// ----------------------------------------------------------------------------
module per_channel_clamped_histogram (
  input  logic       clk_i,
  input  logic       rst_ni,
  pch_cmd_if.sink    in_chan_i,
  pch_res_if.source  out_chan_o
);

  pch_pkg::job_t front_job;
  logic          front_valid;
  logic          front_ready;
  pch_pkg::job_t back_job;
  logic          back_valid;
  logic          back_ready;
  logic          init_busy;

  // The front classifies the command and computes the bin combinationally;
  // the queue registers the result of that.
  pch_front u_front (
    .in_chan_i   (in_chan_i),
    .init_busy_i (init_busy),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  pch_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // The back owns the store and the output register; it takes a new job only
  // when the output register will be free for that job's result.
  pch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_chan_o  (out_chan_o),
    .init_busy_o (init_busy)
  );

endmodule

// ===== hw/rtl/pch_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "per_channel_clamped_histogram_macros.svh"

module pch_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A result that is offered stays offered until it is taken.
  `PCH_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")

  // The clearing pass after reset keeps the command channel closed.
  `PCH_ASSERT(a_init_closed, !$past(rst_ni) || !$past(rst_ni, 2) |-> !in_ready_i, "ready in init")

  // No result can appear while the store is still being cleared after reset.
  `PCH_ASSERT(a_init_quiet, !$past(rst_ni) || !$past(rst_ni, 2) |-> !out_valid_i, "early result")

endmodule

bind per_channel_clamped_histogram pch_checker u_pch_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_chan_i.ready),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready)
);
